// ----- hdl/itoar_pkg.sv -----
// ----------------------------------------------------------------------------
// itoar_pkg: shared types and constants for the integer to ASCII converter
// Command/status structs between controller and datapath, ASCII codes and
// the digit-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itoar_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int STEP_BITS       = 8;   // quotient bits resolved per cycle

   localparam logic [4:0] RADIX_RESET = 5'd10;
   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;

   localparam logic [6:0] ASCII_ZERO  = 7'h30;  // '0'
   localparam logic [6:0] ASCII_A     = 7'h61;  // 'a'
   localparam logic [6:0] ASCII_MINUS = 7'h2d;  // '-'
   localparam logic [6:0] ASCII_NUL   = 7'h00;
   localparam logic [3:0] DIGIT_NINE  = 4'd9;
   localparam logic [3:0] DIGIT_TEN   = 4'd10;

   typedef struct packed {
      logic load;       // capture input value, start conversion
      logic div_step;   // one pass of the divider
      logic push;       // store remainder digit, quotient becomes dividend
      logic pop_load;   // move top digit to the output register
      logic sign_load;  // put '-' in the output register
      logic nul_load;   // put terminator and length in the output register
   } itoar_cmd_type;

   typedef struct packed {
      logic neg;        // value was negative
      logic quot_zero;  // dividend register is zero
      logic cnt_last;   // digit count is one short of the value width
      logic cnt_one;    // one digit left on the stack
      logic cnt_zero;   // digit stack empty
   } itoar_sts_type;

   function automatic logic [6:0] digit_ascii(input logic [3:0] digit);
      logic [3:0] above;
      begin
         above = digit - DIGIT_TEN;
         if (digit > DIGIT_NINE) begin
            digit_ascii = ASCII_A + {3'b000, above};
         end else begin
            digit_ascii = ASCII_ZERO + {3'b000, digit};
         end
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/itoar_dp.sv -----
// ----------------------------------------------------------------------------
// itoar_dp: converter datapath
// Radix register, shift/subtract divider, digit stack and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itoar_dp
   import itoar_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [4:0]                    csr_wr_data,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire itoar_cmd_type                 cmd,
   output      itoar_sts_type                 sts,
   output      logic [6:0]                    rsp_char_code,
   output      logic                          rsp_last,
   output      logic [5:0]                    rsp_length
);

   localparam int PASSES    = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_WIDTH = PASSES * STEP_BITS;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   logic [4:0]                 radix_ff, radix_in;
   logic [DIV_WIDTH-1:0]       div_ff, div_in;
   logic [3:0]                 rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]       cnt_ff, cnt_in;
   logic [5:0]                 len_ff, len_in;
   logic [3:0]                 stk_ff [VALUE_WIDTH];
   logic [6:0]                 char_ff, char_in;
   logic                       last_ff, last_in;
   logic [5:0]                 olen_ff, olen_in;

   logic [VALUE_WIDTH-1:0]     mag;
   logic [STEP_BITS-1:0]       qbits;
   logic [3:0]                 rem_step;

   // radix saturates into 2..16 on write
   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         if (csr_wr_data < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_wr_data > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_wr_data;
         end
      end
   end

   // magnitude through unsigned negate, exact for the most negative value
   assign mag = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   // restoring division, STEP_BITS dividend bits per pass, MSB first
   always_comb begin
      logic [4:0] trial;
      logic [4:0] diff;
      rem_step = rem_ff;
      qbits    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {rem_step, div_ff[DIV_WIDTH-1-i]};
         diff  = trial - radix_ff;
         if (trial >= radix_ff) begin
            qbits[STEP_BITS-1-i] = 1'b1;
            rem_step             = diff[3:0];
         end else begin
            rem_step             = trial[3:0];
         end
      end
   end

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      char_in = char_ff;
      last_in = last_ff;
      olen_in = olen_ff;
      if (cmd.load) begin
         div_in = DIV_WIDTH'(mag);
         rem_in = '0;
         neg_in = req_value[VALUE_WIDTH-1];
         cnt_in = '0;
         len_in = req_value[VALUE_WIDTH-1] ? 6'd2 : 6'd1;
      end
      if (cmd.div_step) begin
         div_in = (div_ff << STEP_BITS) | DIV_WIDTH'(qbits);
         rem_in = rem_step;
      end
      if (cmd.push) begin
         rem_in = '0;
         cnt_in = cnt_ff + 1'b1;
         len_in = len_ff + 6'd1;   // wraps into the 6-bit field
      end
      if (cmd.pop_load) begin
         cnt_in  = cnt_ff - 1'b1;
         char_in = digit_ascii(stk_ff[0]);
         last_in = 1'b0;
         olen_in = '0;
      end
      if (cmd.sign_load) begin
         char_in = ASCII_MINUS;
         last_in = 1'b0;
         olen_in = '0;
      end
      if (cmd.nul_load) begin
         char_in = ASCII_NUL;
         last_in = 1'b1;
         olen_in = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      len_ff  <= len_in;
      char_ff <= char_in;
      last_ff <= last_in;
      olen_ff <= olen_in;
   end

   // digit stack: push enters at the top, pop shifts toward the top
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_ff[0] <= rem_ff;
         for (int i = 1; i < VALUE_WIDTH; i++) begin
            stk_ff[i] <= stk_ff[i-1];
         end
      end else if (cmd.pop_load) begin
         for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
            stk_ff[i] <= stk_ff[i+1];
         end
      end
   end

   always_comb begin
      sts.neg       = neg_ff;
      sts.quot_zero = (div_ff == '0);
      sts.cnt_last  = (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1));
      sts.cnt_one   = (cnt_ff == CNT_WIDTH'(1));
      sts.cnt_zero  = (cnt_ff == '0);
   end

   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_length    = olen_ff;

endmodule

`default_nettype wire

// ----- hdl/itoar_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoar_ctrl: converter controller
// Sequences input capture, divider passes, digit pushes and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module itoar_ctrl
   import itoar_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      itoar_cmd_type cmd,
   input  wire itoar_sts_type sts
);

   localparam int PASSES     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PASS_WIDTH = (PASSES > 1) ? $clog2(PASSES) : 1;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_DIVIDE     = 6'b000010,
      ST_PUSH       = 6'b000100,
      ST_EMIT_SIGN  = 6'b001000,
      ST_EMIT_DIGIT = 6'b010000,
      ST_EMIT_NUL   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [PASS_WIDTH-1:0] pass_ff, pass_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;
   logic                  out_load;

   // output register can take a character when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               pass_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            pass_in      = pass_ff + 1'b1;
            if (pass_ff == PASS_WIDTH'(PASSES - 1)) begin
               pass_in  = '0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (sts.quot_zero || sts.cnt_last) begin
               state_in = sts.neg ? ST_EMIT_SIGN : ST_EMIT_DIGIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_EMIT_SIGN: begin
            if (out_free) begin
               cmd.sign_load = 1'b1;
               state_in      = ST_EMIT_DIGIT;
            end
         end
         ST_EMIT_DIGIT: begin
            if (out_free) begin
               cmd.pop_load = 1'b1;
               if (sts.cnt_one) begin
                  state_in = ST_EMIT_NUL;
               end
            end
         end
         ST_EMIT_NUL: begin
            if (out_free) begin
               cmd.nul_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_load = cmd.sign_load || cmd.pop_load || cmd.nul_load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // accepted transaction starts the divider
   a_accept_divides: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIVIDE))
      else $error("accepted transaction did not start division");

   // output register is never overwritten while a character is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_valid_ff) |-> rsp_ready)
      else $error("output register overwritten before it was taken");

   // digits pending whenever a digit is emitted; none left at the terminator
   a_digit_avail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_DIGIT) |-> !sts.cnt_zero)
      else $error("digit emit with empty stack");

   a_stack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_NUL) |-> sts.cnt_zero)
      else $error("terminator emitted with digits left");

endmodule

`default_nettype wire

// ----- hdl/integer_to_ascii_radix.sv -----
// Sequence: accept, then per digit P = ceil(VALUE_WIDTH/8) divider passes of 8 bits
//   (4 at 32 bits) and a push, then the output characters ('-' if negative, digits,
//   terminator), each waiting until the output register is free. A new value is
//   accepted once the terminator is loaded into the output register.
// The divider loop (P passes and a push per remainder digit) sets the conversion time.
// Reset (synchronous, active high) returns to idle, empties the output and sets radix to 10.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ASCII text in base 2..16
// Converts one signed value per request transaction into a run of response
// transactions: optional '-', digits most significant first, then NUL with
// the character count.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix
   import itoar_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration: radix, saturated into 2..16 when written
   input  wire logic                          csr_wr_en,
   input  wire logic [4:0]                    csr_wr_data,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   // response channel, one character per transaction
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [6:0]                    rsp_char_code,
   output      logic                          rsp_last,
   output      logic [5:0]                    rsp_length
);

   itoar_cmd_type cmd;
   itoar_sts_type sts;

   // Controller: capture, divider passes, digit push, emit sequence.
   // The request side opens again as soon as the terminator sits in the
   // output register, so the next value is taken while it waits.
   itoar_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: magnitude, shift/subtract divider resolving 8 quotient bits a
   // cycle, LIFO of remainder digits (reverses them), and the output register.
   itoar_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_length    (rsp_length)
   );

endmodule

`default_nettype wire
